[src/cap_pkg.sv]
// ----------------------------------------------------------------------------
// cap_pkg: shared types and constants of the cascaded angle/rate PID
// Step codes, command bundle, gain bundle, register indexes and the
// saturation and clamp helpers used by the datapath.
// ----------------------------------------------------------------------------
package cap_pkg;

  // fixed point format of angles and rates
  localparam int FRAC_BITS      = 16;
  localparam int INTEGRAL_LIMIT = 500;

  // field widths
  localparam int DATA_W = 32;
  localparam int GAIN_W = 24;
  localparam int HZ_W   = 16;
  localparam int IDX_W  = 4;

  // integrator bound, capped at the largest 32-bit signed value
  localparam longint INT_LIM_RAW = longint'(INTEGRAL_LIMIT) <<< FRAC_BITS;
  localparam logic signed [63:0] INT_LIM =
    (INT_LIM_RAW > 64'sd2147483647) ? 64'sd2147483647 : 64'(INT_LIM_RAW);

  // outer derivative filter weights, Q0.16 (about 0.4 and 0.6)
  localparam logic signed [24:0] FILT_OLD = 25'sd26214;
  localparam logic signed [24:0] FILT_NEW = 25'sd39322;

  // register reset values
  localparam logic [GAIN_W-1:0] RST_OUTER_KP  = 24'd393216;
  localparam logic [GAIN_W-1:0] RST_OUTER_KI  = 24'd19661;
  localparam logic [GAIN_W-1:0] RST_OUTER_KD  = 24'd26214;
  localparam logic [GAIN_W-1:0] RST_INNER_KP  = 24'd327680;
  localparam logic [GAIN_W-1:0] RST_INNER_KI  = 24'd32768;
  localparam logic [GAIN_W-1:0] RST_INNER_KD  = 24'd11141;
  localparam logic [GAIN_W-1:0] RST_STEP_TIME = 24'd16777;
  localparam logic [HZ_W-1:0]   RST_RATE_HZ   = 16'd1000;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_OUTER_KP     = 4'd0,
    REG_OUTER_KI     = 4'd1,
    REG_OUTER_KD     = 4'd2,
    REG_INNER_KP     = 4'd3,
    REG_INNER_KI     = 4'd4,
    REG_INNER_KD     = 4'd5,
    REG_STEP_TIME    = 4'd6,
    REG_STEP_RATE_HZ = 4'd7
  } reg_e;

  // multiply steps in issue order
  typedef enum logic [3:0] {
    OP_OFILT_OLD = 4'd0,  // old outer filter * 0.4
    OP_OFILT_NEW = 4'd1,  // -rate * 0.6, closes the outer filter
    OP_IDERIV    = 4'd2,  // rate difference * rate_hz, inner filter
    OP_OINT      = 4'd3,  // outer error * step_time, outer integrator
    OP_OP        = 4'd4,  // outer P
    OP_OD        = 4'd5,  // outer D
    OP_OI        = 4'd6,  // outer I, closes rate target
    OP_ID        = 4'd7,  // inner D
    OP_IINT      = 4'd8,  // inner error * step_time, inner integrator
    OP_IP        = 4'd9,  // inner P
    OP_II        = 4'd10  // inner I, closes drive output
  } op_e;

  typedef struct packed {
    logic [GAIN_W-1:0] outer_kp;
    logic [GAIN_W-1:0] outer_ki;
    logic [GAIN_W-1:0] outer_kd;
    logic [GAIN_W-1:0] inner_kp;
    logic [GAIN_W-1:0] inner_ki;
    logic [GAIN_W-1:0] inner_kd;
    logic [GAIN_W-1:0] step_time;
    logic [HZ_W-1:0]   rate_hz;
  } gains_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture a new input item
    logic iss_en;   // multiply the operands of iss_op
    op_e  iss_op;
    logic post_en;  // apply the product of post_op
    op_e  post_op;
  } cmd_t;

  // saturate to 32 signed bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // clamp an integrator sum to the limit
  function automatic logic signed [DATA_W-1:0] clamp_int(input logic signed [63:0] s);
    logic signed [DATA_W-1:0] r;
    if (s > INT_LIM) begin
      r = INT_LIM[DATA_W-1:0];
    end else if (s < -INT_LIM) begin
      r = DATA_W'(-INT_LIM);
    end else begin
      r = s[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[src/cap_regs.sv]
// ----------------------------------------------------------------------------
// cap_regs: gain and timing registers
// Written through the configuration channel; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module cap_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [cap_pkg::IDX_W-1:0]  wr_index_i,
  input  logic [cap_pkg::GAIN_W-1:0] wr_data_i,
  output cap_pkg::gains_t            gains_o
);

  cap_pkg::gains_t gains_q, gains_d;

  // register decode
  always_comb begin
    gains_d = gains_q;
    if (wr_en_i) begin
      unique case (cap_pkg::reg_e'(wr_index_i))
        cap_pkg::REG_OUTER_KP:     gains_d.outer_kp  = wr_data_i;
        cap_pkg::REG_OUTER_KI:     gains_d.outer_ki  = wr_data_i;
        cap_pkg::REG_OUTER_KD:     gains_d.outer_kd  = wr_data_i;
        cap_pkg::REG_INNER_KP:     gains_d.inner_kp  = wr_data_i;
        cap_pkg::REG_INNER_KI:     gains_d.inner_ki  = wr_data_i;
        cap_pkg::REG_INNER_KD:     gains_d.inner_kd  = wr_data_i;
        cap_pkg::REG_STEP_TIME:    gains_d.step_time = wr_data_i;
        cap_pkg::REG_STEP_RATE_HZ: gains_d.rate_hz   = wr_data_i[cap_pkg::HZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.outer_kp  <= cap_pkg::RST_OUTER_KP;
      gains_q.outer_ki  <= cap_pkg::RST_OUTER_KI;
      gains_q.outer_kd  <= cap_pkg::RST_OUTER_KD;
      gains_q.inner_kp  <= cap_pkg::RST_INNER_KP;
      gains_q.inner_ki  <= cap_pkg::RST_INNER_KI;
      gains_q.inner_kd  <= cap_pkg::RST_INNER_KD;
      gains_q.step_time <= cap_pkg::RST_STEP_TIME;
      gains_q.rate_hz   <= cap_pkg::RST_RATE_HZ;
    end else begin
      gains_q <= gains_d;
    end
  end

  assign gains_o = gains_q;

endmodule

[src/cap_ctrl.sv]
// ----------------------------------------------------------------------------
// cap_ctrl: step sequencer
// Walks the eleven multiply steps, one issue per cycle, with the post
// operation of each step applied to its registered product; owns the handshakes.
// ----------------------------------------------------------------------------
module cap_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cap_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  localparam logic [3:0] CntLast = 4'(cap_pkg::OP_II);

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // sequencing
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    in_ready_o     = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.iss_en   = 1'b0;
    cmd_o.iss_op   = cap_pkg::op_e'(cnt_q);
    cmd_o.post_en  = 1'b0;
    cmd_o.post_op  = cap_pkg::op_e'(4'(cnt_q - 4'd1));
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = 4'd0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.iss_en  = 1'b1;
        cmd_o.post_en = (cnt_q != 4'd0);
        if (cnt_q == CntLast) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = 4'(cnt_q + 4'd1);
        end
      end
      ST_FIN: begin
        // last post step waits for a free output register
        cmd_o.post_op = cap_pkg::OP_II;
        cmd_o.post_en = out_free;
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/cap_dp.sv]
// ----------------------------------------------------------------------------
// cap_dp: PID datapath
// One shared 33x25 signed multiplier with a product register, followed by
// the post stage that shifts, filters, integrates, accumulates and saturates.
// ----------------------------------------------------------------------------
module cap_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cap_pkg::cmd_t                     cmd_i,
  input  cap_pkg::gains_t                   gains_i,
  input  logic signed [cap_pkg::DATA_W-1:0] angle_setpoint_i,
  input  logic signed [cap_pkg::DATA_W-1:0] angle_measured_i,
  input  logic signed [cap_pkg::DATA_W-1:0] rate_measured_i,
  input  logic                              clear_integrators_i,
  output logic signed [cap_pkg::DATA_W-1:0] drive_o,
  output logic signed [cap_pkg::DATA_W-1:0] target_o
);

  localparam int DW     = cap_pkg::DATA_W;
  localparam int AW     = DW + 1;
  localparam int BW     = cap_pkg::GAIN_W + 1;
  localparam int PW     = AW + BW;
  localparam int ACC_W  = 46;

  // loop state
  logic signed [DW-1:0] oint_q, ofilt_q, iint_q, prev_q, ifilt_q;
  // per item working registers
  logic signed [AW-1:0]    oerr_q, ierr_q;
  logic signed [DW-1:0]    rate_q, target_q;
  logic signed [PW-1:0]    prod_q, tmp_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [DW-1:0]    drive_out_q, target_out_q;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  // operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.iss_op)
      cap_pkg::OP_OFILT_OLD: begin
        mul_a = AW'(ofilt_q);
        mul_b = cap_pkg::FILT_OLD;
      end
      cap_pkg::OP_OFILT_NEW: begin
        mul_a = -AW'(rate_q);
        mul_b = cap_pkg::FILT_NEW;
      end
      cap_pkg::OP_IDERIV: begin
        mul_a = AW'(prev_q) - AW'(rate_q);
        mul_b = signed'({9'd0, gains_i.rate_hz});
      end
      cap_pkg::OP_OINT: begin
        mul_a = oerr_q;
        mul_b = signed'({1'b0, gains_i.step_time});
      end
      cap_pkg::OP_OP: begin
        mul_a = oerr_q;
        mul_b = signed'({1'b0, gains_i.outer_kp});
      end
      cap_pkg::OP_OD: begin
        mul_a = AW'(ofilt_q);
        mul_b = signed'({1'b0, gains_i.outer_kd});
      end
      cap_pkg::OP_OI: begin
        mul_a = AW'(oint_q);
        mul_b = signed'({1'b0, gains_i.outer_ki});
      end
      cap_pkg::OP_ID: begin
        mul_a = AW'(ifilt_q);
        mul_b = signed'({1'b0, gains_i.inner_kd});
      end
      cap_pkg::OP_IINT: begin
        mul_a = ierr_q;
        mul_b = signed'({1'b0, gains_i.step_time});
      end
      cap_pkg::OP_IP: begin
        mul_a = ierr_q;
        mul_b = signed'({1'b0, gains_i.inner_kp});
      end
      cap_pkg::OP_II: begin
        mul_a = AW'(iint_q);
        mul_b = signed'({1'b0, gains_i.inner_ki});
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // post stage arithmetic
  logic signed [PW-17:0]   gain_term;   // product >> 16
  logic signed [PW-25:0]   int_term;    // product >> 24
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [DW-1:0]    sum_sat;
  logic signed [PW:0]      ofilt_sum, ifilt_sum;
  logic signed [PW-16:0]   ofilt_shr;
  logic signed [PW-1:0]    ifilt_shr;
  logic signed [DW-1:0]    ofilt_new, ifilt_new;
  logic signed [63:0]      oint_sum, iint_sum;
  logic signed [DW-1:0]    oint_new, iint_new;

  always_comb begin
    gain_term = signed'(prod_q[PW-1:16]);
    int_term  = signed'(prod_q[PW-1:24]);
    acc_sum   = acc_q + ACC_W'(gain_term);
    sum_sat   = cap_pkg::sat32(64'(acc_sum));
    ofilt_sum = (PW+1)'(tmp_q) + (PW+1)'(prod_q);
    ofilt_shr = signed'(ofilt_sum[PW:16]);
    ofilt_new = cap_pkg::sat32(64'(ofilt_shr));
    ifilt_sum = (PW+1)'(ifilt_q) + (PW+1)'(prod_q);
    ifilt_shr = signed'(ifilt_sum[PW:1]);
    ifilt_new = cap_pkg::sat32(64'(ifilt_shr));
    oint_sum  = 64'(oint_q) + 64'(int_term);
    iint_sum  = 64'(iint_q) + 64'(int_term);
    oint_new  = cap_pkg::clamp_int(oint_sum);
    iint_new  = cap_pkg::clamp_int(iint_sum);
  end

  // loop state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oint_q  <= '0;
      ofilt_q <= '0;
      iint_q  <= '0;
      prev_q  <= '0;
      ifilt_q <= '0;
    end else begin
      if (cmd_i.load && clear_integrators_i) begin
        oint_q <= '0;
        iint_q <= '0;
      end
      if (cmd_i.post_en) begin
        unique case (cmd_i.post_op)
          cap_pkg::OP_OFILT_NEW: ofilt_q <= ofilt_new;
          cap_pkg::OP_IDERIV: begin
            ifilt_q <= ifilt_new;
            prev_q  <= rate_q;
          end
          cap_pkg::OP_OINT: oint_q <= oint_new;
          cap_pkg::OP_IINT: iint_q <= iint_new;
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      oerr_q <= AW'(angle_setpoint_i) - AW'(angle_measured_i);
      rate_q <= rate_measured_i;
    end
    if (cmd_i.iss_en) begin
      prod_q <= prod;
    end
    if (cmd_i.post_en) begin
      unique case (cmd_i.post_op) inside
        cap_pkg::OP_OFILT_OLD: tmp_q <= prod_q;
        cap_pkg::OP_OP, cap_pkg::OP_ID: acc_q <= ACC_W'(gain_term);
        cap_pkg::OP_OD, cap_pkg::OP_IP: acc_q <= acc_sum;
        cap_pkg::OP_OI: begin
          target_q <= sum_sat;
          ierr_q   <= AW'(sum_sat) - AW'(rate_q);
        end
        cap_pkg::OP_II: begin
          drive_out_q  <= sum_sat;
          target_out_q <= target_q;
        end
        default: ;
      endcase
    end
  end

  assign drive_o  = drive_out_q;
  assign target_o = target_out_q;

endmodule

[src/cascaded_angle_rate_pid.sv]
// ----------------------------------------------------------------------------
// cascaded_angle_rate_pid: one axis cascaded angle/rate PID step
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    setpoint, angle, rate, clear
//   out      output     out_valid_o / out_ready_i  drive_output, rate_target
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// From acceptance to a loaded result, an item runs as follows: the operands
// are captured at the accepting edge, then the multiply steps in turn issue
// one product each through the shared multiplier, and a last step closes the
// inner sum. A new item is taken only after the last one's result is loaded.
// The final step waits while an earlier result is still held at the output.
// Reset clears the loop state and restores the gain registers.
// ----------------------------------------------------------------------------
module cascaded_angle_rate_pid (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [cap_pkg::DATA_W-1:0] angle_setpoint_i,
  input  logic signed [cap_pkg::DATA_W-1:0] angle_measured_i,
  input  logic signed [cap_pkg::DATA_W-1:0] rate_measured_i,
  input  logic                              clear_integrators_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [cap_pkg::DATA_W-1:0] drive_output_o,
  output logic signed [cap_pkg::DATA_W-1:0] rate_target_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cap_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [cap_pkg::GAIN_W-1:0]        cfg_data_i
);

  cap_pkg::cmd_t   cmd;
  cap_pkg::gains_t gains;

  // configuration transfers are always taken
  assign cfg_ready_o = 1'b1;

  cap_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .gains_o    (gains)
  );

  cap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  cap_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .gains_i             (gains),
    .angle_setpoint_i    (angle_setpoint_i),
    .angle_measured_i    (angle_measured_i),
    .rate_measured_i     (rate_measured_i),
    .clear_integrators_i (clear_integrators_i),
    .drive_o             (drive_output_o),
    .target_o            (rate_target_o)
  );

endmodule

[src/cap_checker.sv]
// ----------------------------------------------------------------------------
// cap_checker: port level checks of the cascaded PID
// Handshake hold on the result side and the busy window after an input.
// ----------------------------------------------------------------------------
module cap_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic signed [cap_pkg::DATA_W-1:0] angle_setpoint_i,
  input logic signed [cap_pkg::DATA_W-1:0] angle_measured_i,
  input logic signed [cap_pkg::DATA_W-1:0] rate_measured_i,
  input logic                              clear_integrators_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [cap_pkg::DATA_W-1:0] drive_output_o,
  input logic signed [cap_pkg::DATA_W-1:0] rate_target_o,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [cap_pkg::IDX_W-1:0]         cfg_index_i,
  input logic [cap_pkg::GAIN_W-1:0]        cfg_data_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(drive_output_o) && $stable(rate_target_o))
    else $error("stalled result changed");

  // no new input while an item is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken during a running step");

  // still busy at the closing step of the sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##12 !in_ready_o)
    else $error("step sequence ended early");

  // a result only appears at the end of a step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  // configuration transfers are never refused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration transfer refused");

endmodule

bind cascaded_angle_rate_pid cap_checker u_checker (.*);

[tb/sv/cascaded_angle_rate_pid_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascaded_angle_rate_pid_test: self-checking bench for the cascaded PID step
// Drives angle/rate samples through the valid/ready input channel and
// rewrites the gain registers between phases while the block is idle. A
// bit-exact cascade tracker predicts rate target and drive output for each
// accepted sample, and every output transfer is checked against it in order.
// Phases cover no idling, a slow sender, a stalling receiver, light gaps on
// both sides and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module cascaded_angle_rate_pid_test;
  import cap_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam logic [IDX_W-1:0] SPARE_REG_IDX = 4'd13;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] ONE_DEG = 32'sd65536;
  localparam int unsigned ANGLE_SPAN = 180 * 65536;
  localparam int unsigned RATE_SPAN = 2000 * 65536;

  // arithmetic of the step, Q16.16 throughout
  localparam int GAIN_SHR = 16;
  localparam int DT_SHR = 24;
  localparam longint SMOOTH_OLD = 26214;
  localparam longint SMOOTH_NEW = 39322;
  localparam longint BOUND_RAW = longint'(INTEGRAL_LIMIT) << FRAC_BITS;
  localparam longint INT_BOUND = (BOUND_RAW > 64'sd2147483647) ? 64'sd2147483647 : BOUND_RAW;

  // tracks loop state and gains, queues expected outputs per step
  class pid_cascade_tracker;
    longint outer_kp, outer_ki, outer_kd;
    longint inner_kp, inner_ki, inner_kd;
    longint step_t, rate_hz;
    longint outer_acc, outer_filt, inner_acc, last_rate, inner_filt;
    logic signed [DATA_W-1:0] drive_due[$];
    logic signed [DATA_W-1:0] target_due[$];
    int unsigned faults;

    function new();
      outer_kp = RST_OUTER_KP;
      outer_ki = RST_OUTER_KI;
      outer_kd = RST_OUTER_KD;
      inner_kp = RST_INNER_KP;
      inner_ki = RST_INNER_KI;
      inner_kd = RST_INNER_KD;
      step_t = RST_STEP_TIME;
      rate_hz = RST_RATE_HZ;
      outer_acc = 0;
      outer_filt = 0;
      inner_acc = 0;
      last_rate = 0;
      inner_filt = 0;
      faults = 0;
    endfunction

    function longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint integrate(longint acc, longint err);
      longint s;
      s = acc + ((err * step_t) >>> DT_SHR);
      if (s > INT_BOUND) s = INT_BOUND;
      if (s < -INT_BOUND) s = -INT_BOUND;
      return s;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
      case (idx)
        REG_OUTER_KP:     outer_kp = data;
        REG_OUTER_KI:     outer_ki = data;
        REG_OUTER_KD:     outer_kd = data;
        REG_INNER_KP:     inner_kp = data;
        REG_INNER_KI:     inner_ki = data;
        REG_INNER_KD:     inner_kd = data;
        REG_STEP_TIME:    step_t = data;
        REG_STEP_RATE_HZ: rate_hz = data[HZ_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_step(longint sp, longint ang, longint rate, logic clr);
      longint err, p, i, d, raw, tgt, drv;
      if (clr) begin
        outer_acc = 0;
        inner_acc = 0;
      end
      // outer angle loop
      err = sp - ang;
      p = (err * outer_kp) >>> GAIN_SHR;
      outer_acc = integrate(outer_acc, err);
      i = (outer_acc * outer_ki) >>> GAIN_SHR;
      outer_filt = clip32((outer_filt * SMOOTH_OLD + (-rate) * SMOOTH_NEW) >>> 16);
      d = (outer_filt * outer_kd) >>> GAIN_SHR;
      tgt = clip32(p + i + d);
      // inner rate loop
      err = tgt - rate;
      p = (err * inner_kp) >>> GAIN_SHR;
      inner_acc = integrate(inner_acc, err);
      i = (inner_acc * inner_ki) >>> GAIN_SHR;
      raw = -(rate - last_rate) * rate_hz;
      last_rate = rate;
      inner_filt = clip32((inner_filt + raw) >>> 1);
      d = (inner_filt * inner_kd) >>> GAIN_SHR;
      drv = clip32(p + i + d);
      drive_due.push_back(drv[DATA_W-1:0]);
      target_due.push_back(tgt[DATA_W-1:0]);
    endfunction

    function void check_outputs(logic signed [DATA_W-1:0] drive,
                                logic signed [DATA_W-1:0] target);
      logic signed [DATA_W-1:0] want_drive, want_target;
      if (drive_due.size() == 0) begin
        faults++;
        $display("%0t: output transfer with no step pending: drive %0d, target %0d",
                 $time, drive, target);
        return;
      end
      want_drive = drive_due.pop_front();
      want_target = target_due.pop_front();
      if (want_drive !== drive) begin
        faults++;
        $display("%0t: drive_output mismatch: expected %0d, got %0d",
                 $time, want_drive, drive);
      end
      if (want_target !== target) begin
        faults++;
        $display("%0t: rate_target mismatch: expected %0d, got %0d",
                 $time, want_target, target);
      end
    endfunction

    function int pending();
      return drive_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] sp = '0;
  logic signed [DATA_W-1:0] ang = '0;
  logic signed [DATA_W-1:0] rate = '0;
  logic clr = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] drive;
  logic signed [DATA_W-1:0] target;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;

  pid_cascade_tracker tracker;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned quiet = 0;
  logic signed [DATA_W-1:0] held_sp = '0;

  cascaded_angle_rate_pid dut (
    .clk_i               (clk),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .angle_setpoint_i    (sp),
    .angle_measured_i    (ang),
    .rate_measured_i     (rate),
    .clear_integrators_i (clr),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .drive_output_o      (drive),
    .rate_target_o       (target),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  always #5 clk = ~clk;

  // value pickers for stimulus
  function automatic logic signed [DATA_W-1:0] wide_value();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0: return S32_MAX;
        1: return S32_MIN;
        2: return '0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic signed [DATA_W-1:0] near_value(int unsigned span);
    longint v;
    v = longint'($urandom_range(2 * span)) - longint'(span);
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [GAIN_W-1:0] rand_field(int unsigned bits);
    logic [GAIN_W-1:0] mask, v;
    mask = GAIN_W'((longint'(1) << bits) - 1);
    case ($urandom_range(7))
      0: return '0;
      1: return mask;
      default: begin
        v = GAIN_W'($urandom) & mask;
        return v >> $urandom_range(bits - 4);
      end
    endcase
  endfunction

  // one sample transfer on the input channel
  task automatic send_item(logic signed [DATA_W-1:0] s, logic signed [DATA_W-1:0] a,
                           logic signed [DATA_W-1:0] r, logic c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sp = s;
    ang = a;
    rate = r;
    clr = c;
    do @(posedge clk); while (!in_ready);
    tracker.take_step(s, a, r, c);
    @(negedge clk);
  endtask

  // one register transfer; valid is left high for a following write
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
    @(negedge clk);
  endtask

  // waits for the block to drain, then rewrites every register
  task automatic configure(logic [GAIN_W-1:0] okp, logic [GAIN_W-1:0] oki,
                           logic [GAIN_W-1:0] okd, logic [GAIN_W-1:0] ikp,
                           logic [GAIN_W-1:0] iki, logic [GAIN_W-1:0] ikd,
                           logic [GAIN_W-1:0] dt, logic [GAIN_W-1:0] hz);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    write_reg(REG_OUTER_KP, okp);
    write_reg(REG_OUTER_KI, oki);
    write_reg(REG_OUTER_KD, okd);
    write_reg(REG_INNER_KP, ikp);
    write_reg(REG_INNER_KI, iki);
    write_reg(REG_INNER_KD, ikd);
    write_reg(REG_STEP_TIME, dt);
    write_reg(REG_STEP_RATE_HZ, hz);
    // an unmapped index must leave everything alone
    write_reg(SPARE_REG_IDX, GAIN_W'($urandom));
    cfg_valid = 1'b0;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // output check and watchdog on transfers
  always @(posedge clk) begin
    if (rst_ni) begin
      if (out_valid && out_ready) tracker.check_outputs(drive, target);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, quiet);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [GAIN_W-1:0] hz_cfg;
    tracker = new();
    repeat (12) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // reset gains: zero, extreme errors, clamped integrators, filter overflow
    send_item('0, '0, '0, 1'b0);
    send_item(S32_MAX, S32_MIN, '0, 1'b0);
    send_item(S32_MAX, S32_MIN, '0, 1'b0);
    send_item(S32_MIN, S32_MAX, S32_MIN, 1'b0);
    send_item(S32_MIN, S32_MAX, S32_MIN, 1'b0);
    send_item('0, '0, S32_MAX, 1'b0);
    send_item(ONE_DEG, '0, '0, 1'b1);
    send_item(90 * ONE_DEG, '0, '0, 1'b0);
    send_item(90 * ONE_DEG, 45 * ONE_DEG, -32'sd1, 1'b0);
    send_item('0, '0, -32'sd1, 1'b0);
    send_item(-32'sd1, '0, 32'sd1, 1'b1);
    send_item(32'sh55555555, 32'shaaaaaaaa, 32'sh33333333, 1'b0);

    // full-scale gains: every sum saturates
    configure('1, '1, '1, '1, '1, '1, '1, '1);
    send_item(S32_MAX, S32_MIN, S32_MAX, 1'b0);
    send_item(S32_MIN, S32_MAX, S32_MIN, 1'b0);
    send_item('0, '0, '0, 1'b0);
    send_item(32'sd1, '0, '0, 1'b0);
    send_item(-32'sd1, '0, '0, 1'b0);
    send_item(ONE_DEG, -ONE_DEG, 32'sd7, 1'b1);
    send_item('0, '0, S32_MIN, 1'b0);
    send_item('0, '0, S32_MIN, 1'b0);

    // zero gains, zero step time and zero rate
    configure('0, '0, '0, '0, '0, '0, '0, '0);
    send_item(S32_MAX, S32_MIN, S32_MAX, 1'b0);
    send_item(S32_MIN, S32_MAX, S32_MIN, 1'b1);
    send_item(32'sh0f0f0f0f, 32'shf0f0f0f0, 32'sh7f00ff00, 1'b0);
    send_item('0, '0, '0, 1'b0);

    // random phases with each idling pattern in turn
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        configure(RST_OUTER_KP, RST_OUTER_KI, RST_OUTER_KD, RST_INNER_KP,
                  RST_INNER_KI, RST_INNER_KD, RST_STEP_TIME, GAIN_W'(RST_RATE_HZ));
      end else begin
        hz_cfg = rand_field(HZ_W);
        hz_cfg[GAIN_W-1:HZ_W] = (GAIN_W-HZ_W)'($urandom);
        configure(rand_field(GAIN_W), rand_field(GAIN_W), rand_field(GAIN_W),
                  rand_field(GAIN_W), rand_field(GAIN_W), rand_field(GAIN_W),
                  rand_field(GAIN_W), hz_cfg);
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      // long output hold-off while samples keep coming
      if (ph == 4) hold_req = 600;
      repeat (195) begin
        // setpoint held for a while so the integrators can wind up
        if ($urandom_range(9) == 0) held_sp = wide_value();
        else if ($urandom_range(7) == 0) held_sp = near_value(ANGLE_SPAN / 2);
        send_item(held_sp,
                  ($urandom_range(9) == 0) ? wide_value() : near_value(ANGLE_SPAN),
                  ($urandom_range(9) == 0) ? wide_value() : near_value(RATE_SPAN),
                  $urandom_range(19) == 0);
      end
    end

    // drain
    in_valid = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
